// File: hdl/sample_std_dev_skip_missing_top_assert.svh
// Assertion macros for the sample standard deviation block.
`ifndef SAMPLE_STD_DEV_SKIP_MISSING_TOP_ASSERT_SVH
`define SAMPLE_STD_DEV_SKIP_MISSING_TOP_ASSERT_SVH
// antecedent in one cycle, consequent in the next
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");
// antecedent and consequent in the same cycle
`define SSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");
`endif

// File: hdl/ssd_pkg.sv
// Shared constants and types for the sample standard deviation block.
package ssd_pkg;
    localparam int MAX_LEN_DEF = 1024;
    localparam int DATA_W      = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage

// File: hdl/ssd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ssd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/ssd_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module ssd_div #(
    parameter int NW = 76,
    parameter int DW = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NW-1:0]       dividend,
    input  logic [DW-1:0]       divisor,
    output logic [NW-1:0]       quotient,
    output logic [DW-1:0]       remainder,
    output ssd_pkg::div_stat_t  stat
);
    import ssd_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     r_sh;
    logic [DW:0]     diff;
    logic            ge;

    always_comb
    begin
        r_sh = {r_reg, q_reg[NW-1]};
        diff = r_sh - {1'b0, d_reg};
        ge   = (r_sh >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], ge};
            r_reg <= ge ? diff[DW-1:0] : r_sh[DW-1:0];
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

// File: hdl/sample_std_dev_skip_missing_top.sv
// Top level of the two-pass sample standard deviation block.
//  channel | dir | tdata            | tuser                       | tlast
//  s_*     | in  | [31:0] sample    | [0] is_missing              | last
//  m_*     | out | [31:0] std_dev   | [0] defined, [1] overflowed | -
// While loading, an element is taken whenever s_tvalid is high. After last, the block
// starts the mean divide, makes a pass over the store RAM, restarts the divider for
// the variance divide, takes the root (skipped on saturation) and emits; fewer than
// two present goes straight from start to emit. The shared divider is SQW bits wide
// (SQW = 65 + clog2(MAX_LEN + 1), 76 by default).
// Reset clears the control state and counters; the store needs no clearing.
// s_tready is low from last until the result sits in the output register;
// a stalled result holds there while the next vector loads.
module sample_std_dev_skip_missing_top #(
    parameter int MAX_LEN = ssd_pkg::MAX_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ssd_pkg::DATA_W-1:0] s_tdata,  // [31:0] sample
    input  logic                      s_tuser,   // [0] is_missing
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ssd_pkg::DATA_W-1:0] m_tdata,  // [31:0] std_dev
    output logic [1:0]                m_tuser    // [0] defined, [1] overflowed
);
    import ssd_pkg::*;

    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int AW   = $clog2(MAX_LEN);
    localparam int SW   = DATA_W + CW;
    localparam int SNW  = SW + 2;
    localparam int SQW  = 65 + CW;
    localparam int DVW  = CW + 1;

    typedef enum logic [7:0] {
        ST_LOAD   = 8'b00000001,
        ST_MSTART = 8'b00000010,
        ST_MEAN   = 8'b00000100,
        ST_PASS   = 8'b00001000,
        ST_VSTART = 8'b00010000,
        ST_VAR    = 8'b00100000,
        ST_ROOT   = 8'b01000000,
        ST_EMIT   = 8'b10000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg;
    logic [SW-1:0]   sum_reg;
    logic            ovf_reg;
    logic [CW-1:0]   rd_idx_reg;
    logic            v1_reg, v2_reg, v3_reg;
    logic [32:0]     abs_reg;
    logic [65:0]     sq_reg;
    logic [SQW-1:0]  acc_reg;
    logic [31:0]     mean_reg;
    logic [63:0]     v_reg;
    logic [31:0]     root_reg;
    logic [33:0]     rem_reg;
    logic [4:0]      it_reg;
    logic [31:0]     res_reg;
    logic            def_reg;
    logic            m_valid_reg;
    logic [31:0]     m_data_reg;
    logic [1:0]      m_user_reg;

    logic            acc_in;
    logic            store_ok;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;
    logic            issue;
    logic [SNW-1:0]  num;
    logic            num_neg;
    logic [SNW-1:0]  num_mag;
    logic            div_start;
    logic [SQW-1:0]  div_dividend;
    logic [DVW-1:0]  div_divisor;
    logic [SQW-1:0]  div_q;
    logic [DVW-1:0]  div_r;
    div_stat_t       div_stat;
    logic [32:0]     mean_mag;
    logic [32:0]     mean_full;
    logic [32:0]     dev;
    logic [33:0]     rem_sh;
    logic [33:0]     trial;
    logic            root_ge;
    logic            emit_go;

    assign s_tready = (state_reg == ST_LOAD);
    assign acc_in   = s_tvalid && s_tready;
    assign store_ok = (cnt_reg < CW'(MAX_LEN));
    assign ram_we   = acc_in && !s_tuser && store_ok;
    assign issue    = (state_reg == ST_PASS) && (rd_idx_reg < cnt_reg);
    assign ram_raddr = rd_idx_reg[AW-1:0];
    assign emit_go  = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    ssd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // rounded mean: floor((2*sum + n) / (2*n))
    always_comb
    begin
        num     = {sum_reg[SW-1], sum_reg, 1'b0} + SNW'(cnt_reg);
        num_neg = num[SNW-1];
        num_mag = num_neg ? (~num + 1'b1) : num;
        div_start = (state_reg == ST_MSTART) || (state_reg == ST_VSTART);
        if (state_reg == ST_MSTART)
        begin
            div_dividend = SQW'(num_mag);
            div_divisor  = {cnt_reg, 1'b0};
        end
        else
        begin
            div_dividend = acc_reg;
            div_divisor  = DVW'(cnt_reg - 1'b1);
        end
        mean_mag  = div_q[32:0] + 33'(div_r != '0);
        mean_full = num_neg ? (~mean_mag + 1'b1) : div_q[32:0];
        dev     = {ram_rdata[31], ram_rdata} - {mean_reg[31], mean_reg};
        rem_sh  = {rem_reg[31:0], v_reg[63:62]};
        trial   = {root_reg, 2'b01};
        root_ge = (rem_sh >= trial);
    end

    ssd_div #(.NW(SQW), .DW(DVW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc_in && s_tlast)
                begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART:
            begin
                state_next = (cnt_reg < CW'(2)) ? ST_EMIT : ST_MEAN;
            end
            ST_MEAN:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (!issue && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_VSTART;
                end
            end
            ST_VSTART:
            begin
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                if (div_stat.done)
                begin
                    state_next = (div_q[SQW-1:64] != '0) ? ST_EMIT : ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (it_reg == 5'd31)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            rd_idx_reg  <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            it_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_in && !s_tuser)
            begin
                if (store_ok)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg <= sum_reg + SW'($signed(s_tdata));
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (emit_go)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (state_reg == ST_MSTART)
            begin
                rd_idx_reg <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (state_reg == ST_VAR)
            begin
                it_reg <= '0;
            end
            else if (state_reg == ST_ROOT)
            begin
                it_reg <= it_reg + 1'b1;
            end
            if (emit_go)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg <= dev[32] ? (~dev + 1'b1) : dev;
        sq_reg  <= 66'(abs_reg) * 66'(abs_reg);
        if (state_reg == ST_MSTART)
        begin
            acc_reg <= '0;
            res_reg <= '0;
            def_reg <= 1'b0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + SQW'(sq_reg);
        end
        if ((state_reg == ST_MEAN) && div_stat.done)
        begin
            mean_reg <= mean_full[31:0];
        end
        if ((state_reg == ST_VAR) && div_stat.done)
        begin
            v_reg    <= div_q[63:0];
            root_reg <= '0;
            rem_reg  <= '0;
            def_reg  <= 1'b1;
            res_reg  <= '1;
        end
        if (state_reg == ST_ROOT)
        begin
            v_reg    <= {v_reg[61:0], 2'b00};
            rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], root_ge};
            if (it_reg == 5'd31)
            begin
                res_reg <= {root_reg[30:0], root_ge};
            end
        end
        if (emit_go)
        begin
            m_data_reg <= res_reg;
            m_user_reg <= {ovf_reg, def_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
endmodule

// File: hdl/ssd_checker.sv
// Port-level checker for the sample standard deviation block, with its bind.
`include "sample_std_dev_skip_missing_top_assert.svh"
module ssd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // a stalled result holds
    `SSD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // undefined result reads as zero
    `SSD_ASSERT_SAME(a_undef_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
    // the input closes after the last transaction of a vector
    `SSD_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
endmodule

bind sample_std_dev_skip_missing_top ssd_checker u_ssd_checker (.*);
